FILE: src/qpde_pkg.sv
// ----------------------------------------------------------------------------
// qpde_pkg
// Shared types, constants and helpers of the quintic polynomial /
// derivative evaluator: carried item context, register codes, falling
// factorial table and the 48-bit accumulator clamp.
// ----------------------------------------------------------------------------
package qpde_pkg;

	localparam int unsigned NUM_COEF  = 6;
	localparam int unsigned NUM_STEPS = 5;

	// configuration register codes
	localparam logic [2:0] REG_COEF_0   = 3'd0;
	localparam logic [2:0] REG_COEF_1   = 3'd1;
	localparam logic [2:0] REG_COEF_2   = 3'd2;
	localparam logic [2:0] REG_COEF_3   = 3'd3;
	localparam logic [2:0] REG_COEF_4   = 3'd4;
	localparam logic [2:0] REG_COEF_5   = 3'd5;
	localparam logic [2:0] REG_END_TIME = 3'd6;
	localparam logic [2:0] REG_END_VEL  = 3'd7;

	// derivative order codes
	localparam logic [2:0] ORD_VALUE = 3'd0;
	localparam logic [2:0] ORD_SLOPE = 3'd1;
	localparam logic [2:0] MAX_ORDER = 3'd5;

	// Horner step index of the first step (coefficient of t^4)
	localparam logic [2:0] FIRST_STEP = 3'd4;

	// Q16.16 rounding constant, half an LSB after the 16-bit shift
	localparam logic [15:0] RND_HALF = 16'h8000;

	// accumulator limits, +/-(2^47 - 1)
	localparam logic [46:0]        ACC_MAG_MAX = '1;
	localparam logic signed [47:0] ACC_MAX     = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] ACC_MIN     = -ACC_MAX;
	localparam logic signed [48:0] ACC_MAX_W   = 49'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [48:0] ACC_MIN_W   = -ACC_MAX_W;

	// final Q16.16 limits
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	// falling factorials [order][power index]
	localparam logic [6:0] FALL_FAC [6][6] = '{
		'{7'd1,   7'd1,   7'd1,  7'd1,  7'd1, 7'd1},
		'{7'd1,   7'd2,   7'd3,  7'd4,  7'd5, 7'd0},
		'{7'd2,   7'd6,   7'd12, 7'd20, 7'd0, 7'd0},
		'{7'd6,   7'd24,  7'd60, 7'd0,  7'd0, 7'd0},
		'{7'd24,  7'd120, 7'd0,  7'd0,  7'd0, 7'd0},
		'{7'd120, 7'd0,   7'd0,  7'd0,  7'd0, 7'd0}
	};

	typedef logic [NUM_COEF-1:0][31:0] coef_vec_t;

	// context that travels with each word through the pipeline
	typedef struct packed {
		logic [31:0]        t_mag;     // |time operand| of the Horner chain
		logic               t_neg;     // time operand is negative
		logic [2:0]         order;
		logic               use_chain; // Horner result contributes
		logic               past_end;
		logic [2:0]         step;      // coefficient index of the next step
		logic signed [47:0] acc;
		logic signed [47:0] ext_prod;  // end velocity times overrun
		logic               sat;
	} ctx_t;

	typedef struct packed {
		logic               sat;
		logic signed [47:0] val;
	} acc_sat_t;

	function automatic logic [6:0] fall_fac(input logic [2:0] n, input logic [2:0] j);
		logic [6:0] f;
		f = '0;
		if (n <= MAX_ORDER && j <= MAX_ORDER) begin
			f = FALL_FAC[n][j];
		end
		return f;
	endfunction

	function automatic acc_sat_t clamp_acc(input logic signed [48:0] s);
		acc_sat_t r;
		r.sat = 1'b0;
		r.val = s[47:0];
		if (s > ACC_MAX_W) begin
			r.sat = 1'b1;
			r.val = ACC_MAX;
		end else if (s < ACC_MIN_W) begin
			r.sat = 1'b1;
			r.val = ACC_MIN;
		end
		return r;
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

endpackage

FILE: src/qpde_front.sv
// ----------------------------------------------------------------------------
// qpde_front
// Entry pipeline: end-time compare, operand magnitudes, the extrapolation
// product end_velocity * (t - end_time) and the initial accumulator.
// ----------------------------------------------------------------------------
module qpde_front import qpde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] time_value,
	input  logic [2:0]         derivative_order,
	input  logic signed [31:0] end_time,
	input  logic signed [31:0] end_velocity,
	input  logic signed [31:0] coef_5,
	output logic               out_vld,
	input  logic               out_rdy,
	output ctx_t               out_ctx
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic signed [31:0] t_s1;
	logic [2:0]         ord_s1;

	logic               past_s2;
	logic [32:0]        dt_s2;
	logic [31:0]        opt_s2;
	logic [2:0]         ord_s2;

	ctx_t               ctx_s3;
	logic [31:0]        evmag_s3;
	logic [31:0]        dtmag_s3;
	logic               evneg_s3;

	ctx_t               ctx_s4;
	logic [63:0]        prod_s4;
	logic               evneg_s4;

	ctx_t               ctx_s5;

	logic               past_c;
	logic [32:0]        dt_c;
	ctx_t               ctx3_c;
	logic [64:0]        full_c;
	logic               esat_c;
	logic [47:0]        emag_c;
	logic [47:0]        ext_c;
	ctx_t               ctx5_c;

	// ready chain, a stage takes a word when empty or when it moves on
	assign rdy_s5   = !vld_s5 || out_rdy;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign out_vld  = vld_s5;
	assign out_ctx  = ctx_s5;

	// stage 2: end-time compare and overrun
	always_comb begin
		past_c = t_s1 >= end_time;
		dt_c   = {t_s1[31], t_s1} - {end_time[31], end_time};
	end

	// stage 3: magnitudes, chain enable and leading coefficient
	always_comb begin
		ctx3_c           = '0;
		ctx3_c.t_mag     = abs32(opt_s2);
		ctx3_c.t_neg     = opt_s2[31];
		ctx3_c.order     = ord_s2;
		ctx3_c.past_end  = past_s2;
		ctx3_c.step      = FIRST_STEP;
		ctx3_c.use_chain = past_s2 ? (ord_s2 == ORD_VALUE) : (ord_s2 <= MAX_ORDER);
		if (ctx3_c.use_chain && ord_s2 == ORD_VALUE) begin
			ctx3_c.acc = {{16{coef_5[31]}}, coef_5};
		end
	end

	// stage 5: round, clamp and sign the extrapolation product
	always_comb begin
		full_c          = {1'b0, prod_s4} + 65'(RND_HALF);
		esat_c          = |full_c[64:63];
		emag_c          = {1'b0, (esat_c ? ACC_MAG_MAX : full_c[62:16])};
		ext_c           = evneg_s4 ? (~emag_c + 48'd1) : emag_c;
		ctx5_c          = ctx_s4;
		ctx5_c.ext_prod = ext_c;
		ctx5_c.sat      = ctx_s4.past_end && ctx_s4.order == ORD_VALUE && esat_c;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			t_s1   <= time_value;
			ord_s1 <= derivative_order;
		end
		if (rdy_s2) begin
			past_s2 <= past_c;
			dt_s2   <= dt_c;
			opt_s2  <= past_c ? end_time : t_s1;
			ord_s2  <= ord_s1;
		end
		if (rdy_s3) begin
			ctx_s3   <= ctx3_c;
			evmag_s3 <= abs32(end_velocity);
			evneg_s3 <= end_velocity[31];
			// overrun is non-negative whenever it is used
			dtmag_s3 <= past_s2 ? dt_s2[31:0] : 32'd0;
		end
		if (rdy_s4) begin
			ctx_s4   <= ctx_s3;
			prod_s4  <= 64'(evmag_s3) * 64'(dtmag_s3);
			evneg_s4 <= evneg_s3;
		end
		if (rdy_s5) begin
			ctx_s5 <= ctx5_c;
		end
	end

endmodule

FILE: src/qpde_step.sv
// ----------------------------------------------------------------------------
// qpde_step
// One Horner step acc = clamp(round(acc * t / 2^16) + k * coef), cut into
// four stages: magnitude, split multiply, round/clamp, add/clamp.
// ----------------------------------------------------------------------------
module qpde_step import qpde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_vld,
	output logic      in_rdy,
	input  ctx_t      in_ctx,
	input  coef_vec_t coef,
	output logic      out_vld,
	input  logic      out_rdy,
	output ctx_t      out_ctx
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	ctx_t               ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic [46:0]        amag_s1;
	logic               pneg_s1;
	logic [54:0]        ph_s2;
	logic [55:0]        pl_s2;
	logic               pneg_s2;
	logic [46:0]        mag_s3;
	logic               qsat_s3;
	logic               pneg_s3;
	logic signed [39:0] d_s3;

	logic [47:0]        acc_u;
	logic [47:0]        acc_abs;
	logic [54:0]        ph_c;
	logic [55:0]        pl_c;
	logic [78:0]        full_c;
	logic               qsat_c;
	logic [46:0]        mag_c;
	logic [3:0]         cidx_c;
	logic [31:0]        cval_c;
	logic [6:0]         ff_c;
	logic signed [39:0] d_c;
	logic signed [48:0] d_w;
	logic signed [48:0] m_w;
	logic signed [48:0] sum_c;
	acc_sat_t           cl_c;
	ctx_t               nxt_c;

	assign rdy_s4  = !vld_s4 || out_rdy;
	assign rdy_s3  = !vld_s3 || rdy_s4;
	assign rdy_s2  = !vld_s2 || rdy_s3;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign in_rdy  = rdy_s1;
	assign out_vld = vld_s4;
	assign out_ctx = ctx_s4;

	// stage 1: accumulator magnitude, |acc| < 2^47
	always_comb begin
		acc_u   = in_ctx.acc;
		acc_abs = acc_u[47] ? (~acc_u + 48'd1) : acc_u;
	end

	// stage 2: two partial products, 23x32 and 24x32
	always_comb begin
		ph_c = 55'(amag_s1[46:24]) * 55'(ctx_s1.t_mag);
		pl_c = 56'(amag_s1[23:0]) * 56'(ctx_s1.t_mag);
	end

	// stage 3: recombine, round half away from zero, clamp magnitude
	always_comb begin
		full_c = {ph_s2, 24'd0} + 79'(pl_s2) + 79'(RND_HALF);
		qsat_c = |full_c[78:63];
		mag_c  = qsat_c ? ACC_MAG_MAX : full_c[62:16];
	end

	// stage 3: derivative coefficient k * coef[j + order]
	always_comb begin
		cidx_c = {1'b0, ctx_s2.step} + {1'b0, ctx_s2.order};
		cval_c = '0;
		if (cidx_c <= 4'(MAX_ORDER)) begin
			cval_c = coef[cidx_c[2:0]];
		end
		ff_c = fall_fac(ctx_s2.order, ctx_s2.step);
		d_c  = $signed({1'b0, ff_c}) * $signed(cval_c);
		if (!ctx_s2.use_chain) begin
			d_c = '0;
		end
	end

	// stage 4: signed add and accumulator clamp
	always_comb begin
		d_w       = {{9{d_s3[39]}}, d_s3};
		m_w       = {2'b00, mag_s3};
		sum_c     = pneg_s3 ? (d_w - m_w) : (d_w + m_w);
		cl_c      = clamp_acc(sum_c);
		nxt_c     = ctx_s3;
		nxt_c.acc = cl_c.val;
		nxt_c.sat = ctx_s3.sat | qsat_s3 | cl_c.sat;
		nxt_c.step = ctx_s3.step - 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_vld;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ctx_s1  <= in_ctx;
			amag_s1 <= acc_abs[46:0];
			pneg_s1 <= acc_u[47] ^ in_ctx.t_neg;
		end
		if (rdy_s2) begin
			ctx_s2  <= ctx_s1;
			ph_s2   <= ph_c;
			pl_s2   <= pl_c;
			pneg_s2 <= pneg_s1;
		end
		if (rdy_s3) begin
			ctx_s3  <= ctx_s2;
			mag_s3  <= mag_c;
			qsat_s3 <= qsat_c;
			pneg_s3 <= pneg_s2;
			d_s3    <= d_c;
		end
		if (rdy_s4) begin
			ctx_s4 <= nxt_c;
		end
	end

endmodule

FILE: src/qpde_final.sv
// ----------------------------------------------------------------------------
// qpde_final
// Result selection (polynomial, extrapolated value, end velocity or zero)
// and the 32-bit saturating output register.
// ----------------------------------------------------------------------------
module qpde_final import qpde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	output logic               in_rdy,
	input  ctx_t               in_ctx,
	input  logic signed [31:0] end_velocity,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               saturated
);

	logic vld_s1, vld_s2;
	logic rdy_s1, rdy_s2;

	logic signed [47:0] r_s1;
	logic               sat_s1;
	logic signed [31:0] res_s2;
	logic               sat_s2;

	logic signed [48:0] sum_c;
	acc_sat_t           cl_c;
	logic signed [47:0] r_c;
	logic               sat_c;
	logic               ovf_c;
	logic [31:0]        q_c;

	assign rdy_s2       = !vld_s2 || !out_stall;
	assign rdy_s1       = !vld_s1 || rdy_s2;
	assign in_rdy       = rdy_s1;
	assign out_valid    = vld_s2;
	assign result_value = res_s2;
	assign saturated    = sat_s2;

	// stage 1: pick the result by time region and order
	always_comb begin
		sum_c = {in_ctx.acc[47], in_ctx.acc} + {in_ctx.ext_prod[47], in_ctx.ext_prod};
		cl_c  = clamp_acc(sum_c);
		r_c   = in_ctx.acc;
		sat_c = in_ctx.sat;
		if (in_ctx.past_end) begin
			r_c   = '0;
			sat_c = 1'b0;
			if (in_ctx.order == ORD_VALUE) begin
				r_c   = cl_c.val;
				sat_c = in_ctx.sat | cl_c.sat;
			end else if (in_ctx.order == ORD_SLOPE) begin
				r_c = {{16{end_velocity[31]}}, end_velocity};
			end
		end
	end

	// stage 2: clamp to the 32-bit range
	always_comb begin
		ovf_c = !((&r_s1[47:31]) || !(|r_s1[47:31]));
		q_c   = r_s1[31:0];
		if (ovf_c) begin
			q_c = r_s1[47] ? Q_MIN : Q_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_vld;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			r_s1   <= r_c;
			sat_s1 <= sat_c;
		end
		if (rdy_s2) begin
			res_s2 <= q_c;
			sat_s2 <= sat_s1 | ovf_c;
		end
	end

endmodule

FILE: src/quintic_poly_derivative_eval_unit.sv
// ----------------------------------------------------------------------------
// quintic_poly_derivative_eval_unit
// Evaluates a quintic polynomial or one of its derivatives at a Q16.16
// time, with linear extrapolation past a configured end time.
//
// Usage:
//  - Configuration: write coefficients 0..5, end time and end velocity
//    through cfg_we / cfg_index / cfg_data while no word is in flight.
//    All eight registers clear to zero at reset.
//  - Input channel: in_valid / in_stall carry time_value and
//    derivative_order; a word moves when in_valid is high and in_stall low.
//  - Output channel: out_valid / out_stall carry result_value and the
//    saturated flag, one output word per input word, in order.
//  - Stages: 5 entry stages, 5 Horner steps of 4 stages each (one split
//    47x32 multiply per step), 2 output stages.
//  - Throughput is one word per cycle; the pipeline keeps taking words while
//    the output register is held, until every stage is full.
//  - When the receiver stalls, the output word holds and the pipeline
//    closes up behind it; in_stall rises only once all stages are occupied.
//  - Reset (arst_n low) empties the pipeline at once.
// ----------------------------------------------------------------------------
module quintic_poly_derivative_eval_unit import qpde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] time_value,
	input  logic [2:0]         derivative_order,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               saturated
);

	coef_vec_t          coef_q;
	logic signed [31:0] end_time_q;
	logic signed [31:0] end_vel_q;

	logic chain_vld [NUM_STEPS+1];
	logic chain_rdy [NUM_STEPS+1];
	ctx_t chain_ctx [NUM_STEPS+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q     <= '0;
			end_time_q <= '0;
			end_vel_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_0:   coef_q[0]  <= cfg_data;
				REG_COEF_1:   coef_q[1]  <= cfg_data;
				REG_COEF_2:   coef_q[2]  <= cfg_data;
				REG_COEF_3:   coef_q[3]  <= cfg_data;
				REG_COEF_4:   coef_q[4]  <= cfg_data;
				REG_COEF_5:   coef_q[5]  <= cfg_data;
				REG_END_TIME: end_time_q <= cfg_data;
				REG_END_VEL:  end_vel_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// entry stages
	qpde_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.time_value       (time_value),
		.derivative_order (derivative_order),
		.end_time         (end_time_q),
		.end_velocity     (end_vel_q),
		.coef_5           (coef_q[5]),
		.out_vld          (chain_vld[0]),
		.out_rdy          (chain_rdy[0]),
		.out_ctx          (chain_ctx[0])
	);

	// Horner chain, coefficient of t^4 down to t^0
	for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
		qpde_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (chain_vld[k]),
			.in_rdy  (chain_rdy[k]),
			.in_ctx  (chain_ctx[k]),
			.coef    (coef_q),
			.out_vld (chain_vld[k+1]),
			.out_rdy (chain_rdy[k+1]),
			.out_ctx (chain_ctx[k+1])
		);
	end

	// result select and output register
	qpde_final u_final (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (chain_vld[NUM_STEPS]),
		.in_rdy       (chain_rdy[NUM_STEPS]),
		.in_ctx       (chain_ctx[NUM_STEPS]),
		.end_velocity (end_vel_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.saturated    (saturated)
	);

endmodule

FILE: src/qpde_chk.sv
// ----------------------------------------------------------------------------
// qpde_chk
// Port-level checks of the evaluator: output hold under stall, input stall
// only behind a held word, none while output drains, empty output after reset.
// ----------------------------------------------------------------------------
module qpde_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] result_value,
	input logic               saturated
);

	// a held output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(saturated))
		else $error("output word changed while stalled");

	// the input side only backs up behind a stalled output word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output word");

	// no word can reach the output in the cycle after reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid right after reset");

	// input words are never refused when the output drains freely
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_stall |-> !in_stall)
		else $error("input stalled while output is free");

endmodule

bind quintic_poly_derivative_eval_unit qpde_chk u_qpde_chk (.*);
